@@ rtl/wtsp_pkg.sv @@
`default_nettype none
package wtsp_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int SCREEN_BITS   = 16;

    localparam int COEF_W    = 32;
    localparam int POS_W     = 32;
    localparam int WIN_W     = 14;
    localparam int HALF_W    = WIN_W - 1;
    localparam int NEAR_W    = 31;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;
    localparam int ENTRY_W   = 4;
    localparam int ENTRIES   = 16;

    localparam int PROD_W = COEF_W + POS_W;
    // three floored products plus one entry
    localparam int CLIP_W = PROD_W - FRACTION_BITS + 2;
    localparam int SUM_W  = CLIP_W + 1;
    localparam int NUM_W  = SUM_W + HALF_W + 1;
    localparam int DIV_W  = ((NUM_W > CLIP_W + SCREEN_BITS) ? NUM_W
                                                            : CLIP_W + SCREEN_BITS) + 1;

    localparam int WIDTH_RESET  = 1920;
    localparam int HEIGHT_RESET = 1080;
    localparam int NEAR_RESET   = 6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAYOUT = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_NEAR   = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_PROJECT = 1'b1
    } op_t;

    typedef enum logic {
        LAYOUT_COLUMN = 1'b0,
        LAYOUT_ROW    = 1'b1
    } layout_t;

    // matrix rows 0, 1 and 3 only; column 3 is the constant term
    typedef struct packed {
        logic [POS_W-1:0]              x;
        logic [POS_W-1:0]              y;
        logic [POS_W-1:0]              z;
        logic [2:0][3:0][COEF_W-1:0]   coef;
    } fetch_t;

    typedef struct packed {
        logic              visible;
        logic [NUM_W-1:0]  nx;
        logic [NUM_W-1:0]  ny;
        logic [CLIP_W-1:0] w;
    } numer_t;

    typedef struct packed {
        logic [HALF_W-1:0] half_w;
        logic [HALF_W-1:0] half_h;
        logic [NEAR_W-1:0] near;
    } view_cfg_t;

    typedef struct packed {
        logic                   visible;
        logic [SCREEN_BITS-1:0] sx;
        logic [SCREEN_BITS-1:0] sy;
    } result_t;

endpackage
`default_nettype wire

@@ rtl/wtsp_ifs.sv @@
`default_nettype none
interface wtsp_in_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [wtsp_pkg::ENTRY_W-1:0]       entry_index;
    logic signed [wtsp_pkg::COEF_W-1:0] coefficient;
    logic signed [wtsp_pkg::POS_W-1:0]  pos_x;
    logic signed [wtsp_pkg::POS_W-1:0]  pos_y;
    logic signed [wtsp_pkg::POS_W-1:0]  pos_z;

    modport source (output valid, operation, entry_index, coefficient, pos_x, pos_y, pos_z,
                    input ready);
    modport sink (input valid, operation, entry_index, coefficient, pos_x, pos_y, pos_z,
                  output ready);
endinterface

interface wtsp_out_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    visible;
    logic signed [wtsp_pkg::SCREEN_BITS-1:0] screen_x;
    logic signed [wtsp_pkg::SCREEN_BITS-1:0] screen_y;

    modport source (output valid, visible, screen_x, screen_y, input ready);
    modport sink (input valid, visible, screen_x, screen_y, output ready);
endinterface
`default_nettype wire

@@ rtl/wtsp_coef.sv @@
`default_nettype none
module wtsp_coef (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            operation,
    input  wire logic [wtsp_pkg::ENTRY_W-1:0]    entry_index,
    input  wire logic [wtsp_pkg::COEF_W-1:0]     coefficient,
    input  wire logic [wtsp_pkg::POS_W-1:0]      pos_x,
    input  wire logic [wtsp_pkg::POS_W-1:0]      pos_y,
    input  wire logic [wtsp_pkg::POS_W-1:0]      pos_z,
    input  wire logic                            layout,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output wtsp_pkg::fetch_t                     out_data
);

    logic [wtsp_pkg::COEF_W-1:0] mat_reg [wtsp_pkg::ENTRIES];
    logic                        v_reg;
    wtsp_pkg::fetch_t            data_reg;
    wtsp_pkg::fetch_t            data_next;
    logic                        en;
    logic                        is_load;

    assign en       = !v_reg || out_ready;
    assign in_ready = en;
    assign is_load  = (wtsp_pkg::op_t'(operation) == wtsp_pkg::OP_LOAD);

    always_ff @(posedge clk)
    begin
        if (in_valid && en && is_load)
        begin
            mat_reg[entry_index] <= coefficient;
        end
    end

    // row r of the clip vector, rows 0, 1 and 3 of the matrix
    always_comb
    begin
        data_next.x = pos_x;
        data_next.y = pos_y;
        data_next.z = pos_z;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (wtsp_pkg::layout_t'(layout) == wtsp_pkg::LAYOUT_ROW)
                begin
                    data_next.coef[r][c] = mat_reg[(r == 2 ? 3 : r) * 4 + c];
                end
                else
                begin
                    data_next.coef[r][c] = mat_reg[c * 4 + (r == 2 ? 3 : r)];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid && !is_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

@@ rtl/wtsp_clip.sv @@
`default_nettype none
module wtsp_clip (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire wtsp_pkg::fetch_t   in_data,
    input  wire wtsp_pkg::view_cfg_t cfg,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output wtsp_pkg::numer_t        out_data
);

    localparam int PW = wtsp_pkg::PROD_W;
    localparam int CW = wtsp_pkg::CLIP_W;
    localparam int SW = wtsp_pkg::SUM_W;
    localparam int NW = wtsp_pkg::NUM_W;

    function automatic logic signed [CW-1:0] floor_q(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = p >>> wtsp_pkg::FRACTION_BITS;
        return s[CW-1:0];
    endfunction

    logic v2_reg, v3_reg, v4_reg, v5_reg;
    logic en2, en3, en4, en5;

    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign in_ready = en2;

    // stage 2: products
    logic [2:0][wtsp_pkg::POS_W-1:0] pos;
    logic signed [PW-1:0]            prod [3][3];
    logic signed [PW-1:0]            p_reg [3][3];
    logic [wtsp_pkg::COEF_W-1:0]     k_reg [3];

    assign pos = {in_data.z, in_data.y, in_data.x};

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod[r][c] = $signed(pos[c]) * $signed(in_data.coef[r][c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    p_reg[r][c] <= prod[r][c];
                end
                k_reg[r] <= in_data.coef[r][3];
            end
        end
    end

    // stage 3: clip x, y, w
    logic signed [CW-1:0] clip_reg [3];

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            for (int r = 0; r < 3; r++)
            begin
                clip_reg[r] <= floor_q(p_reg[r][0]) + floor_q(p_reg[r][1])
                             + floor_q(p_reg[r][2]) + CW'($signed(k_reg[r]));
            end
        end
    end

    // stage 4: visibility and offsets
    logic                 vis4_reg;
    logic signed [SW-1:0] sx4_reg, sy4_reg;
    logic signed [CW-1:0] w4_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            vis4_reg <= (clip_reg[2] >= $signed({{(CW-wtsp_pkg::NEAR_W){1'b0}}, cfg.near}))
                        && (clip_reg[2] > $signed(CW'(0)));
            sx4_reg  <= SW'(clip_reg[0]) + SW'(clip_reg[2]);
            sy4_reg  <= SW'(clip_reg[2]) - SW'(clip_reg[1]);
            w4_reg   <= clip_reg[2];
        end
    end

    // stage 5: scale by half window
    logic signed [NW-1:0] nx_next, ny_next;
    wtsp_pkg::numer_t     n5_reg;

    assign nx_next = $signed({1'b0, cfg.half_w}) * sx4_reg;
    assign ny_next = $signed({1'b0, cfg.half_h}) * sy4_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            n5_reg.visible <= vis4_reg;
            n5_reg.nx      <= nx_next;
            n5_reg.ny      <= ny_next;
            n5_reg.w       <= w4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en2) v2_reg <= in_valid;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = n5_reg;

endmodule
`default_nettype wire

@@ rtl/wtsp_div.sv @@
`default_nettype none
module wtsp_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire wtsp_pkg::numer_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output wtsp_pkg::result_t     out_data
);

    localparam int SB = wtsp_pkg::SCREEN_BITS;
    localparam int NW = wtsp_pkg::NUM_W;
    localparam int CW = wtsp_pkg::CLIP_W;
    localparam int DW = wtsp_pkg::DIV_W;

    typedef struct packed {
        logic          sign;
        logic          ovf;
        logic [DW-1:0] rem;
        logic [SB-1:0] q;
    } lane_t;

    typedef struct packed {
        logic          visible;
        logic [CW-1:0] w;
        lane_t         lx;
        lane_t         ly;
    } step_t;

    function automatic logic [SB-1:0] saturate(input lane_t l);
        logic [SB-1:0] hi;
        logic [SB-1:0] lo;
        hi = {1'b0, {(SB-1){1'b1}}};
        lo = {1'b1, {(SB-1){1'b0}}};
        if (!l.sign)
        begin
            return (l.ovf || l.q[SB-1]) ? hi : l.q;
        end
        return (l.ovf || (l.q[SB-1] && |l.q[SB-2:0])) ? lo : (~l.q + SB'(1));
    endfunction

    function automatic lane_t div_step(input lane_t l, input logic [CW-1:0] w, input int sh);
        lane_t         o;
        logic [DW-1:0] d;
        logic          ge;
        d  = DW'(w) << sh;
        ge = (l.rem >= d);
        o  = l;
        o.rem = ge ? (l.rem - d) : l.rem;
        o.q   = {l.q[SB-2:0], ge};
        return o;
    endfunction

    // stage 6: magnitudes
    logic          vm_reg;
    logic          vis_m_reg;
    logic [CW-1:0] w_m_reg;
    logic          sgx_reg, sgy_reg;
    logic [NW-1:0] mx_reg, my_reg;

    logic          v_reg  [SB+1];
    step_t         st_reg [SB+1];
    logic          en_st  [SB+1];
    logic          en_m, en_o;

    logic              vo_reg;
    wtsp_pkg::result_t res_reg;

    assign en_o      = !vo_reg || out_ready;
    assign en_st[SB] = !v_reg[SB] || en_o;
    for (genvar k = 0; k < SB; k++)
    begin : g_en
        assign en_st[k] = !v_reg[k] || en_st[k+1];
    end
    assign en_m     = !vm_reg || en_st[0];
    assign in_ready = en_m;

    always_ff @(posedge clk)
    begin
        if (en_m)
        begin
            vis_m_reg <= in_data.visible;
            w_m_reg   <= in_data.w;
            sgx_reg   <= in_data.nx[NW-1];
            sgy_reg   <= in_data.ny[NW-1];
            mx_reg    <= in_data.nx[NW-1] ? (~in_data.nx + NW'(1)) : in_data.nx;
            my_reg    <= in_data.ny[NW-1] ? (~in_data.ny + NW'(1)) : in_data.ny;
        end
    end

    // stage 7: overflow check when quotient needs more than SB bits
    logic [DW-1:0] wlim;
    assign wlim = DW'(w_m_reg) << SB;

    always_ff @(posedge clk)
    begin
        if (en_st[0])
        begin
            st_reg[0].visible <= vis_m_reg;
            st_reg[0].w       <= w_m_reg;
            st_reg[0].lx.sign <= sgx_reg;
            st_reg[0].lx.ovf  <= (DW'(mx_reg) >= wlim);
            st_reg[0].lx.rem  <= DW'(mx_reg);
            st_reg[0].lx.q    <= '0;
            st_reg[0].ly.sign <= sgy_reg;
            st_reg[0].ly.ovf  <= (DW'(my_reg) >= wlim);
            st_reg[0].ly.rem  <= DW'(my_reg);
            st_reg[0].ly.q    <= '0;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 1; k <= SB; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en_st[k])
            begin
                st_reg[k].visible <= st_reg[k-1].visible;
                st_reg[k].w       <= st_reg[k-1].w;
                st_reg[k].lx      <= div_step(st_reg[k-1].lx, st_reg[k-1].w, SB - k);
                st_reg[k].ly      <= div_step(st_reg[k-1].ly, st_reg[k-1].w, SB - k);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en_st[k])
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            res_reg.visible <= st_reg[SB].visible;
            res_reg.sx      <= st_reg[SB].visible ? saturate(st_reg[SB].lx) : '0;
            res_reg.sy      <= st_reg[SB].visible ? saturate(st_reg[SB].ly) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg   <= 1'b0;
            v_reg[0] <= 1'b0;
            vo_reg   <= 1'b0;
        end
        else
        begin
            if (en_m)     vm_reg   <= in_valid;
            if (en_st[0]) v_reg[0] <= vm_reg;
            if (en_o)     vo_reg   <= v_reg[SB];
        end
    end

    assign out_valid = vo_reg;
    assign out_data  = res_reg;

endmodule
`default_nettype wire

@@ rtl/matrix_world_to_screen_projection_top.sv @@
// channel     | dir | payload
// item_in     | in  | operation, entry_index, coefficient, pos_x, pos_y, pos_z
// result_out  | out | visible, screen_x, screen_y
// cfg_*       | in  | register write: index, data
//
// one item per cycle while the output is not stalled; a projection passes from acceptance to result
// through fetch, 4 multiply/clip stages, 2 divider setup stages, 16 divider stages and output
// loads write the matrix at acceptance and give no result
// per-stage valid bits; bubbles are squeezed out while the output stalls
// rst_n clears valid bits and sets the config registers to their reset values; the matrix is not cleared
`default_nettype none
module matrix_world_to_screen_projection_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    wtsp_in_if.sink                                item_in,
    wtsp_out_if.source                             result_out,
    input  wire logic                              cfg_we,
    input  wire logic [wtsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [wtsp_pkg::CFG_W-1:0]        cfg_data
);

    logic                         layout_reg;
    logic [wtsp_pkg::WIN_W-1:0]   width_reg;
    logic [wtsp_pkg::WIN_W-1:0]   height_reg;
    logic [wtsp_pkg::NEAR_W-1:0]  near_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg <= wtsp_pkg::LAYOUT_COLUMN;
            width_reg  <= wtsp_pkg::WIN_W'(wtsp_pkg::WIDTH_RESET);
            height_reg <= wtsp_pkg::WIN_W'(wtsp_pkg::HEIGHT_RESET);
            near_reg   <= wtsp_pkg::NEAR_W'(wtsp_pkg::NEAR_RESET);
        end
        else if (cfg_we)
        begin
            case (wtsp_pkg::cfg_reg_t'(cfg_index))
                wtsp_pkg::REG_LAYOUT: layout_reg <= cfg_data[0];
                wtsp_pkg::REG_WIDTH:  width_reg  <= cfg_data[wtsp_pkg::WIN_W-1:0];
                wtsp_pkg::REG_HEIGHT: height_reg <= cfg_data[wtsp_pkg::WIN_W-1:0];
                wtsp_pkg::REG_NEAR:   near_reg   <= cfg_data[wtsp_pkg::NEAR_W-1:0];
                default: ;
            endcase
        end
    end

    wtsp_pkg::view_cfg_t view;
    assign view.half_w = width_reg[wtsp_pkg::WIN_W-1:1];
    assign view.half_h = height_reg[wtsp_pkg::WIN_W-1:1];
    assign view.near   = near_reg;

    logic              f_valid, f_ready;
    wtsp_pkg::fetch_t  f_data;
    logic              n_valid, n_ready;
    wtsp_pkg::numer_t  n_data;
    wtsp_pkg::result_t r_data;

    wtsp_coef u_coef (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (item_in.valid),
        .in_ready    (item_in.ready),
        .operation   (item_in.operation),
        .entry_index (item_in.entry_index),
        .coefficient (item_in.coefficient),
        .pos_x       (item_in.pos_x),
        .pos_y       (item_in.pos_y),
        .pos_z       (item_in.pos_z),
        .layout      (layout_reg),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_data    (f_data)
    );

    wtsp_clip u_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .cfg       (view),
        .out_valid (n_valid),
        .out_ready (n_ready),
        .out_data  (n_data)
    );

    wtsp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n_valid),
        .in_ready  (n_ready),
        .in_data   (n_data),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .out_data  (r_data)
    );

    assign result_out.visible  = r_data.visible;
    assign result_out.screen_x = r_data.sx;
    assign result_out.screen_y = r_data.sy;

endmodule
`default_nettype wire

@@ rtl/wtsp_chk.sv @@
`default_nettype none
module wtsp_chk (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic                             visible,
    input wire logic [wtsp_pkg::SCREEN_BITS-1:0] screen_x,
    input wire logic [wtsp_pkg::SCREEN_BITS-1:0] screen_y
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(screen_x) && $stable(screen_y) && $stable(visible))
        else $error("result changed while stalled");

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visible |-> screen_x == '0 && screen_y == '0)
        else $error("invisible point with nonzero pixels");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result right after reset");

endmodule

bind matrix_world_to_screen_projection_top wtsp_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .visible   (result_out.visible),
    .screen_x  (result_out.screen_x),
    .screen_y  (result_out.screen_y)
);
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

    localparam logic [31:0] ONE       = 32'h0001_0000;
    localparam logic [31:0] MINUS_ONE = 32'hFFFF_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] POS_MIN   = 32'h8000_0000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 3000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 85;

    typedef struct {
        wtsp_pkg::op_t     op;
        logic [3:0]        idx;
        logic [31:0]       val;
        logic [31:0]       px;
        logic [31:0]       py;
        logic [31:0]       pz;
        bit                typed;
        wtsp_pkg::result_t res;
    } stim_row_t;

    typedef struct {
        wtsp_pkg::layout_t lay;
        logic [13:0]       wid;
        logic [13:0]       hgt;
        logic [30:0]       nearw;
    } view_setting_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [wtsp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [wtsp_pkg::CFG_W-1:0] cfg_data;

    wtsp_in_if  item_in();
    wtsp_out_if result_out();

    matrix_world_to_screen_projection_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .result_out (result_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // predictor copy of the block state
    logic signed [31:0] coef_table [16];
    wtsp_pkg::layout_t cur_layout;
    logic [13:0] cur_width;
    logic [13:0] cur_height;
    logic [30:0] cur_near;

    wtsp_pkg::result_t screen_q[$];
    int      errors;
    int      n_items;
    int      n_results;
    int      n_visible;
    int      idle_cycles;
    bit      hold_req;
    bit      no_idle;
    bit      typed_now;
    wtsp_pkg::result_t typed_res;

    stim_row_t     rows[$];
    view_setting_t settings[PHASES];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint matrix_entry(int r, int c);
        int idx;
        idx = (cur_layout == wtsp_pkg::LAYOUT_ROW) ? r * 4 + c : c * 4 + r;
        return longint'(coef_table[idx]);
    endfunction

    function automatic longint clip_row(int r, longint x, longint y, longint z);
        return ((x * matrix_entry(r, 0)) >>> wtsp_pkg::FRACTION_BITS)
             + ((y * matrix_entry(r, 1)) >>> wtsp_pkg::FRACTION_BITS)
             + ((z * matrix_entry(r, 2)) >>> wtsp_pkg::FRACTION_BITS)
             + matrix_entry(r, 3);
    endfunction

    function automatic logic [15:0] clamp_pixel(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic wtsp_pkg::result_t project_point(logic signed [31:0] px,
                                                        logic signed [31:0] py,
                                                        logic signed [31:0] pz);
        wtsp_pkg::result_t r;
        longint  cx, cy, cw, hw, hh;
        cx = clip_row(0, px, py, pz);
        cy = clip_row(1, px, py, pz);
        cw = clip_row(3, px, py, pz);
        r = '0;
        if (cw < longint'(cur_near) || cw <= 0)
            return r;
        hw = cur_width / 2;
        hh = cur_height / 2;
        r.visible = 1'b1;
        r.sx = clamp_pixel((hw * (cx + cw)) / cw);
        r.sy = clamp_pixel((hh * (cw - cy)) / cw);
        return r;
    endfunction

    // predictor and scoreboard, sampled at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (wtsp_pkg::cfg_reg_t'(cfg_index))
                    wtsp_pkg::REG_LAYOUT: cur_layout = wtsp_pkg::layout_t'(cfg_data[0]);
                    wtsp_pkg::REG_WIDTH:  cur_width  = cfg_data[13:0];
                    wtsp_pkg::REG_HEIGHT: cur_height = cfg_data[13:0];
                    wtsp_pkg::REG_NEAR:   cur_near   = cfg_data[30:0];
                    default: ;
                endcase
            end
            if (item_in.valid && item_in.ready)
            begin
                n_items++;
                if (wtsp_pkg::op_t'(item_in.operation) == wtsp_pkg::OP_LOAD)
                    coef_table[item_in.entry_index] = item_in.coefficient;
                else if (typed_now)
                    screen_q.push_back(typed_res);
                else
                    screen_q.push_back(project_point(item_in.pos_x, item_in.pos_y,
                                                     item_in.pos_z));
            end
            if (result_out.valid && result_out.ready)
            begin
                wtsp_pkg::result_t e;
                n_results++;
                if (result_out.visible)
                    n_visible++;
                if (screen_q.size() == 0)
                begin
                    $error("result with nothing expected");
                    errors++;
                end
                else
                begin
                    e = screen_q.pop_front();
                    if (result_out.visible !== e.visible)
                    begin
                        $error("visible: expected %0d actual %0d", e.visible,
                               result_out.visible);
                        errors++;
                    end
                    if (result_out.screen_x !== e.sx)
                    begin
                        $error("screen_x: expected %0d actual %0d", $signed(e.sx),
                               result_out.screen_x);
                        errors++;
                    end
                    if (result_out.screen_y !== e.sy)
                    begin
                        $error("screen_y: expected %0d actual %0d", $signed(e.sy),
                               result_out.screen_y);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (!rst_n || (item_in.valid && item_in.ready) || (result_out.valid && result_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // result receiver
    initial
    begin
        result_out.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                result_out.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 34);
        end
    end

    task automatic send_item(wtsp_pkg::op_t op, logic [3:0] idx, logic [31:0] val,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             bit typed, wtsp_pkg::result_t res);
        if (!no_idle)
        begin
            while ($urandom_range(99) < 34)
            begin
                item_in.valid <= 1'b0;
                @(posedge clk);
            end
        end
        item_in.valid       <= 1'b1;
        item_in.operation   <= op;
        item_in.entry_index <= idx;
        item_in.coefficient <= val;
        item_in.pos_x       <= px;
        item_in.pos_y       <= py;
        item_in.pos_z       <= pz;
        typed_now           <= typed;
        typed_res           <= res;
        do
            @(posedge clk);
        while (!item_in.ready);
    endtask

    task automatic load_entry(int idx, logic [31:0] val);
        send_item(wtsp_pkg::OP_LOAD, idx[3:0], val, $urandom, $urandom, $urandom, 1'b0, '0);
    endtask

    task automatic project(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        send_item(wtsp_pkg::OP_PROJECT, 4'($urandom), $urandom, px, py, pz, 1'b0, '0);
    endtask

    // write all registers once the block has gone quiet
    task automatic apply_setting(view_setting_t s);
        item_in.valid <= 1'b0;
        @(posedge clk);
        while (screen_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= wtsp_pkg::REG_LAYOUT;
        cfg_data  <= wtsp_pkg::CFG_W'(s.lay);
        @(posedge clk);
        cfg_index <= wtsp_pkg::REG_WIDTH;
        cfg_data  <= wtsp_pkg::CFG_W'(s.wid);
        @(posedge clk);
        cfg_index <= wtsp_pkg::REG_HEIGHT;
        cfg_data  <= wtsp_pkg::CFG_W'(s.hgt);
        @(posedge clk);
        cfg_index <= wtsp_pkg::REG_NEAR;
        cfg_data  <= wtsp_pkg::CFG_W'(s.nearw);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] small_value(int range_q);
        return 32'($urandom_range(0, 2 * range_q)) - 32'(range_q);
    endfunction

    function automatic stim_row_t mk_row(wtsp_pkg::op_t op, int idx, logic [31:0] val,
                                         logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                         bit typed, bit vis, int sx, int sy);
        stim_row_t r;
        r.op = op;
        r.idx = idx[3:0];
        r.val = val;
        r.px = px;
        r.py = py;
        r.pz = pz;
        r.typed = typed;
        r.res.visible = vis;
        r.res.sx = sx[15:0];
        r.res.sy = sy[15:0];
        return r;
    endfunction

    initial
    begin
        view_setting_t s;
        int lay_row;
        errors = 0;
        n_items = 0;
        n_results = 0;
        n_visible = 0;
        hold_req = 1'b0;
        no_idle = 1'b0;
        typed_now = 1'b0;
        typed_res = '0;
        foreach (coef_table[i])
            coef_table[i] = '0;
        cur_layout = wtsp_pkg::LAYOUT_COLUMN;
        cur_width = 14'(wtsp_pkg::WIDTH_RESET);
        cur_height = 14'(wtsp_pkg::HEIGHT_RESET);
        cur_near = 31'(wtsp_pkg::NEAR_RESET);
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= wtsp_pkg::REG_LAYOUT;
        cfg_data <= '0;
        item_in.valid <= 1'b0;
        item_in.operation <= wtsp_pkg::OP_LOAD;
        item_in.entry_index <= '0;
        item_in.coefficient <= '0;
        item_in.pos_x <= '0;
        item_in.pos_y <= '0;
        item_in.pos_z <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity matrix in column-major order; entries 2 and 10 are never read
        for (int i = 0; i < 16; i++)
        begin
            logic [31:0] v;
            v = (i == 0 || i == 5 || i == 15) ? ONE : 32'h0;
            if (i == 2)
                v = POS_MAX;
            if (i == 10)
                v = POS_MIN;
            rows.push_back(mk_row(wtsp_pkg::OP_LOAD, i, v, 0, 0, 0, 0, 0, 0, 0));
        end
        rows.push_back(mk_row(wtsp_pkg::OP_PROJECT, 0, 0, 0, 0, 0, 1, 1, 960, 540));
        rows.push_back(mk_row(wtsp_pkg::OP_PROJECT, 0, 0, ONE, 0, 0, 1, 1, 1920, 540));
        rows.push_back(mk_row(wtsp_pkg::OP_PROJECT, 0, 0, POS_MAX, 0, 0, 1, 1, 32767, 540));
        rows.push_back(mk_row(wtsp_pkg::OP_PROJECT, 0, 0, POS_MIN, 0, 0, 1, 1, -32768, 540));
        rows.push_back(mk_row(wtsp_pkg::OP_PROJECT, 0, 0, 0, POS_MAX, 0, 1, 1, 960, -32768));
        rows.push_back(mk_row(wtsp_pkg::OP_PROJECT, 0, 0, 0, POS_MIN, 0, 1, 1, 960, 32767));
        rows.push_back(mk_row(wtsp_pkg::OP_PROJECT, 0, 0, 0, 0, POS_MAX, 0, 0, 0, 0));
        rows.push_back(mk_row(wtsp_pkg::OP_PROJECT, 0, 0, POS_MIN, POS_MAX, POS_MIN,
                              0, 0, 0, 0));
        // w now falls with z: z = 1.0 gives w = 0 and an invisible point
        rows.push_back(mk_row(wtsp_pkg::OP_LOAD, 11, MINUS_ONE, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(wtsp_pkg::OP_PROJECT, 0, 0, 0, 0, ONE, 1, 0, 0, 0));
        rows.push_back(mk_row(wtsp_pkg::OP_PROJECT, 0, 0, 0, 0, MINUS_ONE, 1, 1, 960, 540));
        foreach (rows[i])
            send_item(rows[i].op, rows[i].idx, rows[i].val, rows[i].px, rows[i].py,
                      rows[i].pz, rows[i].typed, rows[i].res);
        typed_now <= 1'b0;

        settings[0] = '{wtsp_pkg::LAYOUT_COLUMN, 14'd640, 14'd480, 31'd6554};
        settings[1] = '{wtsp_pkg::LAYOUT_ROW, 14'd1920, 14'd1080, 31'd0};
        settings[2] = '{wtsp_pkg::LAYOUT_COLUMN, 14'd16383, 14'd16383, 31'd65536};
        settings[3] = '{wtsp_pkg::LAYOUT_ROW, 14'd1, 14'd1, 31'd6554};
        settings[4] = '{wtsp_pkg::LAYOUT_COLUMN, 14'd2, 14'd3, 31'h7FFF_FFFF};
        settings[5] = '{wtsp_pkg::LAYOUT_ROW, 14'd3840, 14'd2160, 31'd1};
        settings[6] = '{wtsp_pkg::LAYOUT_ROW, 14'd16383, 14'd1, 31'd100};
        settings[7] = '{wtsp_pkg::LAYOUT_COLUMN, 14'd1000, 14'd16383, 31'd0};

        for (int p = 0; p < PHASES; p++)
        begin
            s = settings[p];
            apply_setting(s);
            lay_row = (s.lay == wtsp_pkg::LAYOUT_ROW);
            if (p == 2)
                hold_req = 1'b1;
            no_idle = (p == 3);
            // a well-formed matrix with a positive w term keeps most points visible
            for (int i = 0; i < 16; i++)
                load_entry(i, (i == 15) ? 32'($urandom_range(65536, 20 * 65536))
                                        : small_value(2 * 65536));
            if (s.nearw == 0)
            begin
                for (int c = 0; c < 4; c++)
                    load_entry(lay_row ? 12 + c : c * 4 + 3, 32'h0);
                project(small_value(100 * 65536), $urandom, 0);
                project($urandom, $urandom, $urandom);
                load_entry(15, ONE);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                int pick;
                pick = $urandom_range(99);
                if (pick < 10)
                    load_entry($urandom_range(15), $urandom);
                else if (pick < 20)
                    load_entry($urandom_range(15), small_value(4 * 65536));
                else if (pick < 75)
                    project(small_value(200 * 65536), small_value(200 * 65536),
                            small_value(200 * 65536));
                else
                    project($urandom, $urandom, $urandom);
            end
        end
        item_in.valid <= 1'b0;
        no_idle = 1'b0;
        @(posedge clk);
        while (screen_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d items accepted, %0d points projected, %0d visible", n_items,
                 n_results, n_visible);
        $display("run: both matrix layouts, window sizes 1 to 16383, near limits 0 to max");
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/wtsp_pkg.sv
rtl/wtsp_ifs.sv
rtl/wtsp_coef.sv
rtl/wtsp_clip.sv
rtl/wtsp_div.sv
rtl/matrix_world_to_screen_projection_top.sv
rtl/wtsp_chk.sv
test/testbench.sv
